[sv/pct_pkg.sv]
// percent encode/decode stream: shared types, codes and character helpers
// no dependencies; imported by the core, pct_xform and pct_serial
`default_nettype none

package pct_pkg;

	localparam logic [7:0] PCT_CHAR = 8'h25;

	// mode register codes
	localparam logic [1:0] MODE_ESCAPE = 2'd0;
	localparam logic [1:0] MODE_ENCODE = 2'd1;
	localparam logic [1:0] MODE_DECODE = 2'd2;

	// decoder hold state
	localparam logic [1:0] HELD_NONE  = 2'd0;
	localparam logic [1:0] HELD_PCT   = 2'd1;
	localparam logic [1:0] HELD_DIGIT = 2'd2;

	localparam int unsigned GRP_DEPTH = 3;

	// all output bytes caused by one input beat
	typedef struct packed {
		logic [GRP_DEPTH-1:0][7:0] bytes;
		logic [1:0]                cnt;
		logic                      last;
	} grp_t;

	function automatic logic is_hex(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		v = c[3:0];
		if (c <= 8'h39) begin
			return v;
		end
		return v + 4'd9;
	endfunction

	function automatic logic [7:0] hex_upper(input logic [3:0] v);
		if (v < 4'd10) begin
			return {4'h3, v};
		end
		return 8'h37 + {4'h0, v};
	endfunction

	function automatic logic in_escape_set(input logic [7:0] c);
		return c inside {[8'h00:8'h29], 8'h2C, [8'h3A:8'h3F], [8'h5B:8'h5E], 8'h60,
			[8'h7B:8'hFF]};
	endfunction

	function automatic logic in_encode_set(input logic [7:0] c);
		return c inside {[8'h00:8'h20], [8'h22:8'h26], 8'h2B, 8'h2C, 8'h2F,
			[8'h3A:8'h40], [8'h5B:8'h5E], 8'h60, [8'h7B:8'h7D], [8'h7F:8'hFF]};
	endfunction

endpackage

`default_nettype wire

[sv/pct_ifs.sv]
// percent encode/decode stream: valid/ready channel interfaces
// input beats, result beats and the mode write channel; no dependencies
`default_nettype none

interface pct_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface pct_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, out_byte, out_last, input ready);
	modport sink (input valid, out_byte, out_last, output ready);
endinterface

interface pct_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;

	modport source (output valid, mode, input ready);
	modport sink (input valid, mode, output ready);
endinterface

`default_nettype wire

[sv/percent_encode_decode_stream_core.sv]
// percent encode/decode stream core: while the result register is free, one input
// beat per cycle is taken into a transform and its 0..3 result bytes are registered there
// first result byte is valid the cycle after the input beat is taken
// one input beat per cycle while each yields at most one byte and the result is taken;
// an escaped byte holds the single result port for all three of its bytes
// reset: mode returns to escape, decoder hold empties, result register empties
`default_nettype none

module percent_encode_decode_stream_core (
	input  wire          clk,
	input  wire          arst_n,
	pct_cfg_if.sink      cfg,
	pct_in_if.sink       item,
	pct_out_if.source    result
);
	import pct_pkg::*;

	grp_t grp;
	logic free;
	logic acc;
	logic cfg_we;

	assign cfg.ready  = 1'b1;
	assign cfg_we     = cfg.valid && cfg.ready;
	assign item.ready = free;
	assign acc        = item.valid && free;

	pct_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_mode (cfg.mode),
		.acc      (acc),
		.in_byte  (item.in_byte),
		.in_last  (item.in_last),
		.grp      (grp)
	);

	// beats that produce nothing only move the hold state
	pct_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (acc && (grp.cnt != 2'd0)),
		.grp       (grp),
		.free      (free),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_byte  (result.out_byte),
		.out_last  (result.out_last)
	);

endmodule

`default_nettype wire

[sv/pct_xform.sv]
// percent encode/decode stream: mode register, decoder hold state and the
// per-beat transform into a group of up to three bytes; uses pct_pkg
`default_nettype none

module pct_xform (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire [1:0]        cfg_mode,
	input  wire              acc,
	input  wire [7:0]        in_byte,
	input  wire              in_last,
	output pct_pkg::grp_t    grp
);
	import pct_pkg::*;

	logic [1:0] mode_q;
	logic [1:0] held_q;
	logic [7:0] digit_q;
	logic [1:0] held_d;
	logic [7:0] digit_d;

	always_comb begin
		logic [1:0] n;
		logic       fresh;
		logic [7:0] vals [GRP_DEPTH];
		n       = 2'd0;
		fresh   = 1'b1;
		held_d  = held_q;
		digit_d = digit_q;
		for (int i = 0; i < GRP_DEPTH; i++) begin
			vals[i] = 8'h00;
		end

		case (mode_q)
			MODE_ESCAPE, MODE_ENCODE: begin
				if ((mode_q == MODE_ESCAPE) ? in_escape_set(in_byte)
						: in_encode_set(in_byte)) begin
					vals[0] = PCT_CHAR;
					vals[1] = hex_upper(in_byte[7:4]);
					vals[2] = hex_upper(in_byte[3:0]);
					n = 2'd3;
				end else begin
					vals[0] = in_byte;
					n = 2'd1;
				end
			end
			MODE_DECODE: begin
				case (held_q)
					HELD_PCT: begin
						if (is_hex(in_byte)) begin
							digit_d = in_byte;
							held_d  = HELD_DIGIT;
							fresh   = 1'b0;
						end else begin
							vals[0] = PCT_CHAR;
							n       = 2'd1;
							held_d  = HELD_NONE;
						end
					end
					HELD_DIGIT: begin
						if (is_hex(in_byte)) begin
							vals[0] = {hex_val(digit_q), hex_val(in_byte)};
							n       = 2'd1;
							fresh   = 1'b0;
						end else begin
							vals[0] = PCT_CHAR;
							vals[1] = digit_q;
							n       = 2'd2;
						end
						held_d  = HELD_NONE;
						digit_d = 8'h00;
					end
					default: begin
						held_d = HELD_NONE;
					end
				endcase
				// the breaking byte is scanned again from an empty hold
				if (fresh) begin
					if (in_byte == PCT_CHAR) begin
						held_d = HELD_PCT;
					end else begin
						vals[n] = in_byte;
						n = n + 2'd1;
					end
				end
				// end of string flushes whatever is still held
				if (in_last) begin
					if (held_d != HELD_NONE) begin
						vals[n] = PCT_CHAR;
						n = n + 2'd1;
					end
					if (held_d == HELD_DIGIT) begin
						vals[n] = digit_d;
						n = n + 2'd1;
					end
					held_d  = HELD_NONE;
					digit_d = 8'h00;
				end
			end
			default: begin
				vals[0] = in_byte;
				n = 2'd1;
			end
		endcase

		for (int i = 0; i < GRP_DEPTH; i++) begin
			grp.bytes[i] = vals[i];
		end
		grp.cnt  = n;
		grp.last = in_last && (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ESCAPE;
			held_q  <= HELD_NONE;
			digit_q <= 8'h00;
		end else if (cfg_we) begin
			mode_q  <= cfg_mode;
			held_q  <= HELD_NONE;
			digit_q <= 8'h00;
		end else if (acc) begin
			held_q  <= held_d;
			digit_q <= digit_d;
		end
	end

	a_hold_only_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != HELD_NONE) |-> (mode_q == MODE_DECODE))
		else $error("hold state outside decode mode");

	a_held_digit_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == HELD_DIGIT) |-> is_hex(digit_q))
		else $error("held digit is not a hex character");

	a_last_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_last && !cfg_we) |=> (held_q == HELD_NONE))
		else $error("hold not emptied at end of string");

endmodule

`default_nettype wire

[sv/pct_serial.sv]
// percent encode/decode stream: result register holding one byte group and
// the index that walks it out one beat at a time; uses pct_pkg
`default_nettype none

module pct_serial (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              load,
	input  pct_pkg::grp_t    grp,
	output logic             free,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last
);
	import pct_pkg::*;

	grp_t       grp_s1;
	logic       vld_s1;
	logic [1:0] idx_q;
	logic       final_beat;
	logic       fire;

	assign final_beat = (idx_q == grp_s1.cnt - 2'd1);
	assign fire       = vld_s1 && out_ready;
	// a new group may land when the slot is empty or its last byte leaves now
	assign free       = !vld_s1 || (fire && final_beat);

	assign out_valid = vld_s1;
	assign out_byte  = grp_s1.bytes[idx_q];
	assign out_last  = grp_s1.last && final_beat;

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s1 <= grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load) begin
			vld_s1 <= 1'b1;
			idx_q  <= 2'd0;
		end else if (fire) begin
			if (final_beat) begin
				vld_s1 <= 1'b0;
				idx_q  <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	a_group_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (grp_s1.cnt != 2'd0 && idx_q < grp_s1.cnt))
		else $error("result index outside its group");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("group loaded over one still draining");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !final_beat && !load) |=> (vld_s1 && idx_q == $past(idx_q) + 2'd1))
		else $error("result index did not advance");

endmodule

`default_nettype wire
